[hdl/cus_pkg.sv]
// shared types and constants of the conservative update sketch
package cus_pkg;

   localparam int CNT_W      = 31;
   localparam int KEY_LO_W   = 64;
   localparam int KEY_HI_W   = 40;
   localparam int AMOUNT_W   = 16;
   localparam int SEED_W     = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int SEED_COUNT = 4;
   localparam int MM_SHIFT   = 47;

   localparam logic [CNT_W-1:0] CNT_MAX   = 31'h7fffffff;
   localparam logic [63:0]      MM_MUL    = 64'hc6a4a7935bd1e995;
   localparam logic [63:0]      KEY_BYTES = 64'd13;
   localparam logic [63:0]      MM_HX     = MM_MUL * KEY_BYTES;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW0 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW1 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW2 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW3 = 8'd3;

   localparam logic [SEED_W-1:0] SEED_RESET0 = 64'd541;
   localparam logic [SEED_W-1:0] SEED_RESET1 = 64'd1211;
   localparam logic [SEED_W-1:0] SEED_RESET2 = 64'd1862;
   localparam logic [SEED_W-1:0] SEED_RESET3 = 64'd1094;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_K1,
      ST_K2,
      ST_H1,
      ST_H2,
      ST_H3,
      ST_MOD,
      ST_RD,
      ST_MIN,
      ST_WR,
      ST_DONE
   } state_type;

endpackage

[hdl/cus_mul.sv]
// iterative 64-bit multiply by the hash constant, low 64 bits, one 32x32 product a cycle
module cus_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [63:0] result
);
   import cus_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] x, y;
   logic [63:0] prod;

   always_comb begin
      x    = (step_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      y    = (step_ff == 2'd1) ? MM_MUL[63:32] : MM_MUL[31:0];
      prod = {32'b0, x} * {32'b0, y};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         a_in    = operand;
      end else if (busy_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = prod;
         end else begin
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

   always_ff @(posedge clock) begin
      assert property (disable iff (reset) start |-> !busy_ff)
         else $error("multiplier started while busy");
      assert property (disable iff (reset) done_ff |-> !busy_ff)
         else $error("multiplier done while still busy");
      assert property (disable iff (reset) (busy_ff && step_ff == 2'd2) |=> done_ff)
         else $error("multiplier missed its done pulse");
   end

endmodule

[hdl/cus_rem.sv]
// remainder of a 64-bit hash by the row width, folded with a constant then finished by compare-subtract
module cus_rem #(
   parameter int ROW_WIDTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [63:0]                  value,
   output logic                         done,
   output logic [$clog2(ROW_WIDTH)-1:0] remainder
);

   localparam int PW = $clog2(ROW_WIDTH);
   localparam int K  = PW + 4;
   localparam logic [63:0]   RW_C      = 64'(ROW_WIDTH);
   localparam logic [63:0]   R_FULL    = (64'd1 << K) % RW_C;
   localparam logic [PW-1:0] R_C       = PW'(R_FULL);
   localparam logic [2:0]    LAST_STEP = 3'd5;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                sub_ff, sub_in;
   logic [2:0]          step_ff, step_in;
   logic [63:0]         x_ff, x_in;
   logic [63-K:0]       fold_hi;
   logic [K-1:0]        fold_lo;
   logic [63-K+PW:0]    fold_prod;
   logic [63:0]         fold_val;
   logic [63:0]         sub_mult;

   always_comb begin
      fold_hi   = x_ff[63:K];
      fold_lo   = x_ff[K-1:0];
      // 2^K is congruent to R_C, so the high part folds down with one small product
      fold_prod = {{PW{1'b0}}, fold_hi} * {{(64-K){1'b0}}, R_C};
      fold_val  = 64'(fold_prod) + {{(64-K){1'b0}}, fold_lo};
      sub_mult  = RW_C << step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      sub_in    = sub_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      if (start) begin
         busy_in = 1'b1;
         sub_in  = 1'b0;
         step_in = LAST_STEP;
         x_in    = value;
      end else if (busy_ff) begin
         if (!sub_ff) begin
            // below 2^(K+1) the value is under 64 row widths
            if (x_ff[63:K+1] == '0) begin
               sub_in  = 1'b1;
               step_in = LAST_STEP;
            end else begin
               x_in = fold_val;
            end
         end else begin
            if (x_ff >= sub_mult) begin
               x_in = x_ff - sub_mult;
            end
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sub_ff  <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         sub_ff  <= sub_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
   end

   assign done      = done_ff;
   assign remainder = x_ff[PW-1:0];

   always_ff @(posedge clock) begin
      assert property (disable iff (reset) start |-> !busy_ff)
         else $error("remainder unit started while busy");
      assert property (disable iff (reset) done_ff |-> (x_ff < RW_C))
         else $error("remainder not below row width");
      assert property (disable iff (reset) (busy_ff && sub_ff && step_ff == 3'd0) |=> done_ff)
         else $error("remainder unit missed its done pulse");
   end

endmodule

[hdl/cus_ctr_ram.sv]
// counter memory, one write and one registered read port
module cus_ctr_ram #(
   parameter int AW = 14
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  logic [cus_pkg::CNT_W-1:0] wdata,
   input  logic [AW-1:0]           raddr,
   output logic [cus_pkg::CNT_W-1:0] rdata
);
   import cus_pkg::*;

   logic [CNT_W-1:0] mem [2**AW];
   logic [CNT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/conservative_update_sketch_unit.sv]
// conservative update count-min sketch, top level
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall key_lo, key_hi, amount
//   rsp      out        rsp_valid/rsp_stall estimate
//   csr      in         csr_valid/csr_ready index, wdata
//
// one transaction at a time, passing through the shared 32x32 multiplier for each
// 64-bit product and the remainder unit (constant folds, then six compare-subtract steps)
// after reset a clearing pass zeroes the counter memory, 2^(row bits + index bits)
// words (16384 at the defaults), with req_stall high
// a finished estimate waits in the output register while the next request is taken
module conservative_update_sketch_unit #(
   parameter int ROW_WIDTH = 4096,
   parameter int NUM_ROWS  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cus_pkg::KEY_LO_W-1:0]      req_key_lo,
   input  logic [cus_pkg::KEY_HI_W-1:0]      req_key_hi,
   input  logic [cus_pkg::AMOUNT_W-1:0]      req_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cus_pkg::CNT_W-1:0]         rsp_estimate,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cus_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cus_pkg::SEED_W-1:0]        csr_wdata
);
   import cus_pkg::*;

   localparam int PW = $clog2(ROW_WIDTH);
   localparam int RI = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int RC = $clog2(NUM_ROWS + 1);
   localparam int AW = RI + PW;
   localparam logic [RC-1:0] LAST_ROW = RC'(NUM_ROWS - 1);
   localparam logic [RC-1:0] ROWS_C   = RC'(NUM_ROWS);

   state_type state_ff, state_in;
   logic                issued_ff, issued_in;
   logic [KEY_LO_W-1:0] key_lo_ff, key_lo_in;
   logic [KEY_HI_W-1:0] key_hi_ff, key_hi_in;
   logic [AMOUNT_W-1:0] amount_ff, amount_in;
   logic [63:0]         k_ff, k_in;
   logic [63:0]         h_ff, h_in;
   logic [RC-1:0]       row_ff, row_in;
   logic [PW-1:0]       pos_ff [NUM_ROWS];
   logic [PW-1:0]       pos_in [NUM_ROWS];
   logic [CNT_W-1:0]    cnt_ff [NUM_ROWS];
   logic [CNT_W-1:0]    cnt_in [NUM_ROWS];
   logic [CNT_W-1:0]    target_ff, target_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    estimate_ff, estimate_in;
   logic [SEED_W-1:0]   seed_ff [SEED_COUNT];

   logic             mul_start, mul_done;
   logic [63:0]      mul_operand, mul_result;
   logic             rem_start, rem_done;
   logic [PW-1:0]    rem_result;
   logic [63:0]      h_fin;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [CNT_W-1:0] ram_wdata, ram_rdata;
   logic [CNT_W-1:0] row_min;
   logic [CNT_W:0]   sum;
   logic [RI-1:0]    row_idx;
   logic [RI-1:0]    prev_idx;
   logic [CNT_W-1:0] wr_value;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff[0] <= SEED_RESET0;
         seed_ff[1] <= SEED_RESET1;
         seed_ff[2] <= SEED_RESET2;
         seed_ff[3] <= SEED_RESET3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEED_ROW0: seed_ff[0] <= csr_wdata;
            CSR_SEED_ROW1: seed_ff[1] <= csr_wdata;
            CSR_SEED_ROW2: seed_ff[2] <= csr_wdata;
            CSR_SEED_ROW3: seed_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign row_idx  = row_ff[RI-1:0];
   assign prev_idx = RI'(row_ff - RC'(1));
   assign h_fin    = h_ff ^ (h_ff >> MM_SHIFT);

   always_comb begin
      row_min = CNT_MAX;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (cnt_ff[r] < row_min) begin
            row_min = cnt_ff[r];
         end
      end
      sum      = {1'b0, row_min} + {{(CNT_W+1-AMOUNT_W){1'b0}}, amount_ff};
      wr_value = (cnt_ff[row_idx] > target_ff) ? cnt_ff[row_idx] : target_ff;
   end

   always_comb begin
      mul_operand = key_lo_ff;
      unique case (state_ff)
         ST_K2:   mul_operand = k_ff ^ (k_ff >> MM_SHIFT);
         ST_H1:   mul_operand = seed_ff[2'(row_ff)] ^ MM_HX ^ k_ff;
         ST_H2:   mul_operand = h_ff ^ {{(64-KEY_HI_W){1'b0}}, key_hi_ff};
         ST_H3:   mul_operand = h_fin;
         default: mul_operand = key_lo_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      key_lo_in    = key_lo_ff;
      key_hi_in    = key_hi_ff;
      amount_in    = amount_ff;
      k_in         = k_ff;
      h_in         = h_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      target_in    = target_ff;
      clr_in       = clr_ff;
      estimate_in  = estimate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start    = 1'b0;
      rem_start    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = {row_idx, pos_ff[row_idx]};
      ram_wdata    = wr_value;
      ram_raddr    = {row_idx, pos_ff[row_idx]};
      req_stall    = 1'b1;

      unique case (state_ff) inside
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               key_lo_in = req_key_lo;
               key_hi_in = req_key_hi;
               amount_in = req_amount;
               issued_in = 1'b0;
               state_in  = ST_K1;
            end
         end
         ST_K1, ST_K2, ST_H1, ST_H2, ST_H3: begin
            mul_start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  ST_K1: begin
                     k_in     = mul_result;
                     state_in = ST_K2;
                  end
                  ST_K2: begin
                     k_in     = mul_result;
                     row_in   = '0;
                     state_in = ST_H1;
                  end
                  ST_H1: begin
                     h_in     = mul_result;
                     state_in = ST_H2;
                  end
                  ST_H2: begin
                     h_in     = mul_result;
                     state_in = ST_H3;
                  end
                  default: begin
                     h_in     = mul_result;
                     state_in = ST_MOD;
                  end
               endcase
            end
         end
         ST_MOD: begin
            rem_start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (rem_done) begin
               issued_in       = 1'b0;
               pos_in[row_idx] = rem_result;
               if (row_ff == LAST_ROW) begin
                  row_in   = '0;
                  state_in = ST_RD;
               end else begin
                  row_in   = row_ff + RC'(1);
                  state_in = ST_H1;
               end
            end
         end
         ST_RD: begin
            // read data of the previous row lands in the cycle after its address
            if (row_ff != '0) begin
               cnt_in[prev_idx] = ram_rdata;
            end
            if (row_ff == ROWS_C) begin
               state_in = ST_MIN;
            end else begin
               row_in = row_ff + RC'(1);
            end
         end
         ST_MIN: begin
            target_in = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
            row_in    = '0;
            state_in  = ST_WR;
         end
         ST_WR: begin
            ram_we = 1'b1;
            if (row_ff == LAST_ROW) begin
               state_in = ST_DONE;
            end else begin
               row_in = row_ff + RC'(1);
            end
         end
         ST_DONE: begin
            // new minimum equals the target: every counter below it is raised to it
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               estimate_in  = target_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issued_ff    <= 1'b0;
         row_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         row_ff       <= row_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_lo_ff   <= key_lo_in;
      key_hi_ff   <= key_hi_in;
      amount_ff   <= amount_in;
      k_ff        <= k_in;
      h_ff        <= h_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      target_ff   <= target_in;
      estimate_ff <= estimate_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = estimate_ff;

   cus_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_operand),
      .done    (mul_done),
      .result  (mul_result)
   );

   cus_rem #(
      .ROW_WIDTH (ROW_WIDTH)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .value     (h_fin),
      .done      (rem_done),
      .remainder (rem_result)
   );

   cus_ctr_ram #(
      .AW (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      assert property (disable iff (reset) (req_valid && !req_stall) |=> state_ff == ST_K1)
         else $error("accepted transaction did not start hashing");
      assert property (disable iff (reset)
                       ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_WR))
         else $error("counter write outside clear or update");
      assert property (disable iff (reset) state_ff == ST_CLEAR |-> req_stall)
         else $error("request taken during clearing pass");
      assert property (disable iff (reset) (rsp_valid && rsp_stall)
                       |=> (rsp_valid && $stable(rsp_estimate)))
         else $error("stalled estimate changed or dropped");
   end

endmodule
